// File: rtl/spx_pkg.sv
// spectrum to xyz: shared widths, sequencer states and the d50 / cie 1931 rom tables
// used by every file of the block except spx_ram; depends on nothing
`default_nettype none

package spx_pkg;

	localparam int MAX_BANDS   = 16;
	localparam int BAND_AW     = $clog2(MAX_BANDS);
	localparam int BAND_CW     = $clog2(MAX_BANDS + 1);
	localparam int GRID_POINTS = 71;
	localparam int GRID_IW     = $clog2(GRID_POINTS);

	localparam int WL_W   = 14;
	localparam int VAL_W  = 16;
	localparam int OUT_W  = 16;
	localparam int D50_W  = 17;
	localparam int CMF_W  = 21;
	localparam int MUL_AW = 33;
	localparam int MUL_BW = 21;
	localparam int PROD_W = MUL_AW + MUL_BW;
	localparam int NUMI_W = 31;
	localparam int ACC_W  = 61;
	localparam int K_W    = 44;
	localparam int NUM_W  = 64;
	localparam int DEN_W  = K_W + 5;
	localparam int QUO_W  = OUT_W + 1;
	localparam int STEP_W = $clog2(QUO_W + 1);

	localparam logic [WL_W-1:0] GRID_START = WL_W'(6080);
	localparam logic [WL_W-1:0] GRID_STEP  = WL_W'(80);
	localparam logic [GRID_IW-1:0] GRID_LAST = GRID_IW'(GRID_POINTS - 1);

	typedef enum logic [4:0] {
		S_IDLE,
		S_PT,
		S_SCAN_RD,
		S_SCAN_CHK,
		S_MUL_A,
		S_MUL_B,
		S_DIV_GO,
		S_DIV_WAIT,
		S_MUL_RW,
		S_MUL_X,
		S_MUL_Y,
		S_MUL_Z,
		S_MUL_K,
		S_ACC_K,
		S_SC_PREP,
		S_SC_GO,
		S_SC_WAIT,
		S_OUT
	} spx_state_t;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [OUT_W-1:0] quo;
	} div_rsp_t;

	localparam logic [D50_W-1:0] D50_ROM [GRID_POINTS] = '{
		17'd24488, 17'd27179, 17'd29871, 17'd39589, 17'd49308, 17'd52910, 17'd56513,
		17'd58273, 17'd60034, 17'd58926, 17'd57818, 17'd66321, 17'd74825, 17'd81036,
		17'd87247, 17'd88930, 17'd90612, 17'd90990, 17'd91368, 17'd93238, 17'd95109,
		17'd93536, 17'd91963, 17'd93843, 17'd95724, 17'd96169, 17'd96613, 17'd96871,
		17'd97129, 17'd99614, 17'd102099, 17'd101427, 17'd100755, 17'd101536,
		17'd102317, 17'd101159, 17'd100000, 17'd98868, 17'd97735, 17'd98327,
		17'd98918, 17'd96208, 17'd93499, 17'd95593, 17'd97688, 17'd98478, 17'd99269,
		17'd99155, 17'd99042, 17'd97382, 17'd95722, 17'd97290, 17'd98857, 17'd97262,
		17'd95667, 17'd96929, 17'd98190, 17'd100597, 17'd103003, 17'd101068,
		17'd99133, 17'd93257, 17'd87381, 17'd89492, 17'd91604, 17'd92246, 17'd92889,
		17'd84872, 17'd76854, 17'd81683, 17'd86511
	};

	localparam logic [CMF_W-1:0] XBAR_ROM [GRID_POINTS] = '{
		21'd1368, 21'd2236, 21'd4243, 21'd7650, 21'd14310, 21'd23190, 21'd43510,
		21'd77630, 21'd134380, 21'd214770, 21'd283900, 21'd328500, 21'd348280,
		21'd348060, 21'd336200, 21'd318700, 21'd290800, 21'd251100, 21'd195360,
		21'd142100, 21'd95640, 21'd57950, 21'd32010, 21'd14700, 21'd4900, 21'd2400,
		21'd9300, 21'd29100, 21'd63270, 21'd109600, 21'd165500, 21'd225750,
		21'd290400, 21'd359700, 21'd433450, 21'd512050, 21'd594500, 21'd678400,
		21'd762100, 21'd842500, 21'd916300, 21'd978600, 21'd1026300, 21'd1056700,
		21'd1062200, 21'd1045600, 21'd1002600, 21'd938400, 21'd854450, 21'd751400,
		21'd642400, 21'd541900, 21'd447900, 21'd360800, 21'd283500, 21'd218700,
		21'd164900, 21'd121200, 21'd87400, 21'd63600, 21'd46770, 21'd32900,
		21'd22700, 21'd15840, 21'd11359, 21'd8111, 21'd5790, 21'd4109, 21'd2899,
		21'd2049, 21'd1440
	};

	localparam logic [CMF_W-1:0] YBAR_ROM [GRID_POINTS] = '{
		21'd39, 21'd64, 21'd120, 21'd217, 21'd396, 21'd640, 21'd1210, 21'd2180,
		21'd4000, 21'd7300, 21'd11600, 21'd16840, 21'd23000, 21'd29800, 21'd38000,
		21'd48000, 21'd60000, 21'd73900, 21'd90980, 21'd112600, 21'd139020,
		21'd169300, 21'd208020, 21'd258600, 21'd323000, 21'd407300, 21'd503000,
		21'd608200, 21'd710000, 21'd793200, 21'd862000, 21'd914850, 21'd954000,
		21'd980300, 21'd994950, 21'd1000000, 21'd995000, 21'd978600, 21'd952000,
		21'd915400, 21'd870000, 21'd816300, 21'd757000, 21'd694900, 21'd631000,
		21'd566800, 21'd503000, 21'd441200, 21'd381000, 21'd321000, 21'd265000,
		21'd217000, 21'd175000, 21'd138200, 21'd107000, 21'd81600, 21'd61000,
		21'd44580, 21'd32000, 21'd23200, 21'd17000, 21'd11920, 21'd8210, 21'd5723,
		21'd4102, 21'd2929, 21'd2091, 21'd1484, 21'd1047, 21'd740, 21'd520
	};

	localparam logic [CMF_W-1:0] ZBAR_ROM [GRID_POINTS] = '{
		21'd6450, 21'd10550, 21'd20050, 21'd36210, 21'd67850, 21'd110200,
		21'd207400, 21'd371300, 21'd645600, 21'd1039050, 21'd1385600, 21'd1622960,
		21'd1747060, 21'd1782600, 21'd1772110, 21'd1744100, 21'd1669200,
		21'd1528100, 21'd1287640, 21'd1041900, 21'd812950, 21'd616200, 21'd465180,
		21'd353300, 21'd272000, 21'd212300, 21'd158200, 21'd111700, 21'd78250,
		21'd57250, 21'd42160, 21'd29840, 21'd20300, 21'd13400, 21'd8750, 21'd5750,
		21'd3900, 21'd2750, 21'd2100, 21'd1800, 21'd1650, 21'd1400, 21'd1100,
		21'd1000, 21'd800, 21'd600, 21'd340, 21'd240, 21'd190, 21'd100, 21'd50,
		21'd30, 21'd20, 21'd10, 21'd0, 21'd0, 21'd0, 21'd0, 21'd0, 21'd0, 21'd0,
		21'd0, 21'd0, 21'd0, 21'd0, 21'd0, 21'd0, 21'd0, 21'd0, 21'd0, 21'd0
	};

endpackage

`default_nettype wire

// File: rtl/spx_if.sv
// spectrum to xyz: valid/ready channel interfaces for band requests and xyz results
// depends on spx_pkg
`default_nettype none

interface spx_band_if import spx_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [WL_W-1:0]  band_wavelength;
	logic [VAL_W-1:0] reflectance;
	logic             last_band;

	modport source (output valid, band_wavelength, reflectance, last_band, input ready);
	modport sink (input valid, band_wavelength, reflectance, last_band, output ready);
endinterface

interface spx_xyz_if import spx_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [OUT_W-1:0] tristim_x;
	logic [OUT_W-1:0] tristim_y;
	logic [OUT_W-1:0] tristim_z;
	logic             order_error;
	logic             band_overflow;

	modport source (output valid, tristim_x, tristim_y, tristim_z, order_error,
		band_overflow, input ready);
	modport sink (input valid, tristim_x, tristim_y, tristim_z, order_error,
		band_overflow, output ready);
endinterface

`default_nettype wire

// File: rtl/spx_ram.sv
// spectrum to xyz: generic single write port ram with registered read
// no dependencies
`default_nettype none

module spx_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// File: rtl/spx_mul.sv
// spectrum to xyz: shared unsigned multiplier with registered product
// depends on spx_pkg
`default_nettype none

module spx_mul import spx_pkg::*; (
	input  wire logic              clk,
	input  wire logic [MUL_AW-1:0] a,
	input  wire logic [MUL_BW-1:0] b,
	output      logic [PROD_W-1:0] prod_q
);

	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(a) * PROD_W'(b);
	end

endmodule

`default_nettype wire

// File: rtl/spx_div.sv
// spectrum to xyz: shared restoring divider, one quotient bit per cycle
// saturates to the 16-bit range; depends on spx_pkg
`default_nettype none

module spx_div import spx_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_req_t req,
	output      div_rsp_t rsp
);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [DEN_W-1:0]  rem_q;
	logic [DEN_W-1:0]  den_q;
	logic [QUO_W-1:0]  lo_q;
	logic [QUO_W-1:0]  quo_q;
	logic [DEN_W:0]    trial;
	logic              fit;
	logic              too_big;

	assign trial   = {rem_q, lo_q[QUO_W-1]};
	assign fit     = trial >= {1'b0, den_q};
	// quotient would need more than QUO_W bits
	assign too_big = (DEN_W + 1)'(req.num[NUM_W-1:QUO_W]) >= {1'b0, req.den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				if (too_big) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					step_q <= STEP_W'(QUO_W);
				end
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			den_q <= req.den;
			rem_q <= DEN_W'(req.num[NUM_W-1:QUO_W]);
			lo_q  <= req.num[QUO_W-1:0];
			quo_q <= too_big ? '1 : '0;
		end else if (busy_q) begin
			rem_q <= fit ? DEN_W'(trial - {1'b0, den_q}) : DEN_W'(trial);
			lo_q  <= {lo_q[QUO_W-2:0], 1'b0};
			quo_q <= {quo_q[QUO_W-2:0], fit};
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quo  = quo_q[QUO_W-1] ? '1 : quo_q[OUT_W-1:0];

endmodule

`default_nettype wire

// File: rtl/spectrum_to_xyz.sv
// Spectrum to CIE 1931 XYZ under D50. Bands are loaded one request per cycle into a
// 16-entry store; the request with last_band starts a walk over 71 grid points
// (380-730 nm, 5 nm) and the block takes no request until the result is placed in
// the output register. A grid point outside the band range goes straight to the
// weighting multiplies; otherwise it scans the stored bands and then runs the
// interpolation multiplies, the divide and the weighting multiplies. The three final
// scalings use the divider, or saturate when the sum is too large; all steps share
// the single multiplier and divider.
// Depends on spx_pkg, spx_if, spx_ram, spx_mul and spx_div.
`default_nettype none

module spectrum_to_xyz import spx_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	spx_band_if.sink  band,
	spx_xyz_if.source xyz
);

	localparam int SAT_BIT = NUM_W - 5;

	spx_state_t state_q, state_d;

	logic [BAND_CW-1:0] cnt_q;
	logic               order_q;
	logic               ovf_q;
	logic [WL_W-1:0]    first_wl_q, last_wl_q, prev_wl_q, w1_q, g_q;
	logic [VAL_W-1:0]   first_val_q, last_val_q, prev_val_q, v1_q, r_q;
	logic [BAND_AW-1:0] scan_a_q;
	logic [GRID_IW-1:0] pt_q;
	logic [NUMI_W-1:0]  numi_q;
	logic [MUL_AW-1:0]  rw_q;
	logic [ACC_W-1:0]   sx_q, sy_q, sz_q;
	logic [K_W-1:0]     sk_q;
	logic [NUM_W-1:0]   scale_q;
	logic [1:0]         ch_q;
	logic [OUT_W-1:0]   res_q [3];
	logic               out_valid_q;
	logic [OUT_W-1:0]   out_x_q, out_y_q, out_z_q;
	logic               out_ord_q, out_ovf_q;

	logic               accept, store_we;
	logic [WL_W-1:0]    rd_wl;
	logic [VAL_W-1:0]   rd_val;
	logic [MUL_AW-1:0]  mul_a;
	logic [MUL_BW-1:0]  mul_b;
	logic [PROD_W-1:0]  prod_q;
	div_req_t           div_req;
	div_rsp_t           div_rsp;
	logic [ACC_W-1:0]   s_sel;
	logic               s_big;
	logic               ch_last;
	logic               out_free;
	logic [WL_W-1:0]    d;

	assign accept   = band.valid && band.ready;
	assign store_we = accept && (cnt_q != BAND_CW'(MAX_BANDS));
	assign d        = w1_q - prev_wl_q;
	assign ch_last  = ch_q == 2'd2;
	assign out_free = !out_valid_q || xyz.ready;

	always_comb begin
		case (ch_q)
			2'd0:    s_sel = sx_q;
			2'd1:    s_sel = sy_q;
			default: s_sel = sz_q;
		endcase
	end
	assign s_big = s_sel[ACC_W-1:SAT_BIT] != '0;

	spx_ram #(.WIDTH(WL_W), .DEPTH(MAX_BANDS)) u_wl_ram (
		.clk   (clk),
		.we    (store_we),
		.waddr (cnt_q[BAND_AW-1:0]),
		.wdata (band.band_wavelength),
		.raddr (scan_a_q),
		.rdata (rd_wl)
	);

	spx_ram #(.WIDTH(VAL_W), .DEPTH(MAX_BANDS)) u_val_ram (
		.clk   (clk),
		.we    (store_we),
		.waddr (cnt_q[BAND_AW-1:0]),
		.wdata (band.reflectance),
		.raddr (scan_a_q),
		.rdata (rd_val)
	);

	spx_mul u_mul (
		.clk    (clk),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod_q)
	);

	spx_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept && band.last_band) state_d = S_PT;
			end
			S_PT: begin
				if (g_q <= first_wl_q || g_q >= last_wl_q) state_d = S_MUL_RW;
				else state_d = S_SCAN_RD;
			end
			S_SCAN_RD:  state_d = S_SCAN_CHK;
			S_SCAN_CHK: state_d = (rd_wl < g_q) ? S_SCAN_RD : S_MUL_A;
			S_MUL_A:    state_d = S_MUL_B;
			S_MUL_B:    state_d = S_DIV_GO;
			S_DIV_GO:   state_d = S_DIV_WAIT;
			S_DIV_WAIT: begin
				if (div_rsp.done) state_d = S_MUL_RW;
			end
			S_MUL_RW:   state_d = S_MUL_X;
			S_MUL_X:    state_d = S_MUL_Y;
			S_MUL_Y:    state_d = S_MUL_Z;
			S_MUL_Z:    state_d = S_MUL_K;
			S_MUL_K:    state_d = S_ACC_K;
			S_ACC_K:    state_d = (pt_q == GRID_LAST) ? S_SC_PREP : S_PT;
			S_SC_PREP:  state_d = S_SC_GO;
			S_SC_GO: begin
				if (!s_big) state_d = S_SC_WAIT;
				else state_d = ch_last ? S_OUT : S_SC_PREP;
			end
			S_SC_WAIT: begin
				if (div_rsp.done) state_d = ch_last ? S_OUT : S_SC_PREP;
			end
			S_OUT: begin
				if (out_free) state_d = S_IDLE;
			end
			default:    state_d = S_IDLE;
		endcase
	end

	// unit controls
	always_comb begin
		mul_a       = '0;
		mul_b       = '0;
		div_req     = '0;
		band.ready  = 1'b0;
		case (state_q)
			S_IDLE:  band.ready = 1'b1;
			S_MUL_A: begin
				mul_a = MUL_AW'(prev_val_q);
				mul_b = MUL_BW'(w1_q - g_q);
			end
			S_MUL_B: begin
				mul_a = MUL_AW'(v1_q);
				mul_b = MUL_BW'(g_q - prev_wl_q);
			end
			S_DIV_GO: begin
				div_req.start = 1'b1;
				div_req.num   = NUM_W'(numi_q) + NUM_W'(prod_q[NUMI_W-1:0]) +
					NUM_W'(d >> 1);
				div_req.den   = DEN_W'(d);
			end
			S_MUL_RW: begin
				mul_a = MUL_AW'(r_q);
				mul_b = MUL_BW'(D50_ROM[pt_q]);
			end
			S_MUL_X: begin
				mul_a = prod_q[MUL_AW-1:0];
				mul_b = XBAR_ROM[pt_q];
			end
			S_MUL_Y: begin
				mul_a = rw_q;
				mul_b = YBAR_ROM[pt_q];
			end
			S_MUL_Z: begin
				mul_a = rw_q;
				mul_b = ZBAR_ROM[pt_q];
			end
			S_MUL_K: begin
				mul_a = MUL_AW'(D50_ROM[pt_q]);
				mul_b = YBAR_ROM[pt_q];
			end
			S_SC_GO: begin
				div_req.start = !s_big;
				div_req.num   = scale_q + NUM_W'({sk_q, 4'b0});
				div_req.den   = {sk_q, 5'b0};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			order_q     <= 1'b0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				if (store_we) begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q != '0 && band.band_wavelength <= last_wl_q) order_q <= 1'b1;
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (xyz.ready) out_valid_q <= 1'b0;
			if (state_q == S_OUT && out_free) begin
				out_valid_q <= 1'b1;
				cnt_q       <= '0;
				order_q     <= 1'b0;
				ovf_q       <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (store_we) begin
			last_wl_q  <= band.band_wavelength;
			last_val_q <= band.reflectance;
			if (cnt_q == '0) begin
				first_wl_q  <= band.band_wavelength;
				first_val_q <= band.reflectance;
			end
		end
		case (state_q)
			S_IDLE: begin
				g_q  <= GRID_START;
				pt_q <= '0;
				sx_q <= '0;
				sy_q <= '0;
				sz_q <= '0;
				sk_q <= '0;
				ch_q <= '0;
			end
			S_PT: begin
				if (g_q <= first_wl_q) r_q <= first_val_q;
				else if (g_q >= last_wl_q) r_q <= last_val_q;
				scan_a_q   <= BAND_AW'(1);
				prev_wl_q  <= first_wl_q;
				prev_val_q <= first_val_q;
			end
			S_SCAN_CHK: begin
				if (rd_wl < g_q) begin
					prev_wl_q  <= rd_wl;
					prev_val_q <= rd_val;
					scan_a_q   <= scan_a_q + 1'b1;
				end else begin
					w1_q <= rd_wl;
					v1_q <= rd_val;
				end
			end
			S_MUL_B:    numi_q <= prod_q[NUMI_W-1:0];
			S_DIV_WAIT: begin
				if (div_rsp.done) r_q <= div_rsp.quo;
			end
			S_MUL_X:    rw_q <= prod_q[MUL_AW-1:0];
			S_MUL_Y:    sx_q <= sx_q + ACC_W'(prod_q);
			S_MUL_Z:    sy_q <= sy_q + ACC_W'(prod_q);
			S_MUL_K:    sz_q <= sz_q + ACC_W'(prod_q);
			S_ACC_K: begin
				sk_q <= sk_q + K_W'(prod_q);
				g_q  <= g_q + GRID_STEP;
				pt_q <= pt_q + 1'b1;
			end
			// times 25 by shift and add, s is known below 2^59 when used
			S_SC_PREP: scale_q <= (NUM_W'(s_sel) << 4) + (NUM_W'(s_sel) << 3) + NUM_W'(s_sel);
			S_SC_GO: begin
				if (s_big) begin
					res_q[ch_q] <= '1;
					ch_q        <= ch_q + 1'b1;
				end
			end
			S_SC_WAIT: begin
				if (div_rsp.done) begin
					res_q[ch_q] <= div_rsp.quo;
					ch_q        <= ch_q + 1'b1;
				end
			end
			S_OUT: begin
				if (out_free) begin
					out_x_q   <= res_q[0];
					out_y_q   <= res_q[1];
					out_z_q   <= res_q[2];
					out_ord_q <= order_q;
					out_ovf_q <= ovf_q;
				end
			end
			default: ;
		endcase
	end

	assign xyz.valid         = out_valid_q;
	assign xyz.tristim_x     = out_x_q;
	assign xyz.tristim_y     = out_y_q;
	assign xyz.tristim_z     = out_z_q;
	assign xyz.order_error   = out_ord_q;
	assign xyz.band_overflow = out_ovf_q;

`ifndef ASSERT_OFF
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= BAND_CW'(MAX_BANDS))
		else $error("band count beyond store depth");

	a_scan_in_store: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN_CHK |-> BAND_CW'(scan_a_q) < cnt_q)
		else $error("scan read past stored bands");

	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy)
		else $error("divider started while busy");

	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_OUT))
		else $error("result raised outside output state");
`endif

endmodule

`default_nettype wire
